[design/numeric_literal_validator_defines.svh]
// ----------------------------------------------------------------------------
// numeric_literal_validator_defines.svh
// Assertion macros shared by the checker of the literal validator.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_VALIDATOR_DEFINES_SVH
`define NUMERIC_LITERAL_VALIDATOR_DEFINES_SVH

// same-cycle implication, off while reset is held
`define NLV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define NLV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live during reset
`define NLV_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/nlv_pkg.sv]
// ----------------------------------------------------------------------------
// nlv_pkg
// Character classes, token type and queue sizing for the literal validator.
// ----------------------------------------------------------------------------
package nlv_pkg;

    typedef logic [2:0] t_cls;

    localparam t_cls CLS_DIGIT = 3'd0;
    localparam t_cls CLS_SPACE = 3'd1;
    localparam t_cls CLS_SIGN  = 3'd2;
    localparam t_cls CLS_POINT = 3'd3;
    localparam t_cls CLS_EXPO  = 3'd4;
    localparam t_cls CLS_OTHER = 3'd5;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_tok;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

[design/nlv_if.sv]
// ----------------------------------------------------------------------------
// nlv_if
// Channels of the literal validator: character requests in, verdicts out.
// ----------------------------------------------------------------------------
interface nlv_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       is_last;

    modport source (output valid, output symbol, output is_last, input ready);
    modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface nlv_res_if;
    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);
endinterface

[design/nlv_front.sv]
// ----------------------------------------------------------------------------
// nlv_front
// Accepts character requests and reduces each byte to a character class.
// ----------------------------------------------------------------------------
module nlv_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_symbol,
    input  logic          i_is_last,
    output logic          o_push,
    output nlv_pkg::t_tok o_tok,
    input  logic          i_q_ready
);

    nlv_pkg::t_cls cls;

    always_comb begin
        if (i_symbol >= 8'h30 && i_symbol <= 8'h39) begin
            cls = nlv_pkg::CLS_DIGIT;
        end else begin
            case (i_symbol)
                8'h20:         cls = nlv_pkg::CLS_SPACE;
                8'h2B, 8'h2D:  cls = nlv_pkg::CLS_SIGN;
                8'h2E:         cls = nlv_pkg::CLS_POINT;
                8'h45, 8'h65:  cls = nlv_pkg::CLS_EXPO;
                default:       cls = nlv_pkg::CLS_OTHER;
            endcase
        end
    end

    assign o_ready    = i_q_ready;
    assign o_push     = i_valid & i_q_ready;
    assign o_tok.cls  = cls;
    assign o_tok.last = i_is_last;

endmodule

[design/nlv_queue.sv]
// ----------------------------------------------------------------------------
// nlv_queue
// Short token queue between the classifier and the automaton.
// ----------------------------------------------------------------------------
module nlv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nlv_pkg::t_tok i_tok,
    output logic          o_ready,
    output logic          o_valid,
    output nlv_pkg::t_tok o_tok,
    input  logic          i_pop
);

    localparam logic [nlv_pkg::QPTR_W-1:0] LAST_IDX = nlv_pkg::QPTR_W'(nlv_pkg::QUEUE_DEPTH - 1);
    localparam logic [nlv_pkg::QCNT_W-1:0] FULL_CNT = nlv_pkg::QCNT_W'(nlv_pkg::QUEUE_DEPTH);

    nlv_pkg::t_tok                r_mem [nlv_pkg::QUEUE_DEPTH];
    logic [nlv_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [nlv_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [nlv_pkg::QCNT_W-1:0]   r_cnt, n_cnt;
    logic                         do_push, do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_IDX) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_IDX) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

endmodule

[design/nlv_back.sv]
// ----------------------------------------------------------------------------
// nlv_back
// Scan automaton, verdict register; one token per cycle, a last may stall.
// ----------------------------------------------------------------------------
module nlv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  nlv_pkg::t_tok i_tok,
    output logic          o_pop,
    output logic          o_res_valid,
    output logic          o_is_valid,
    input  logic          i_res_ready
);

    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_SIGN  = 4'd1;
    localparam logic [3:0] ST_INT   = 4'd2;
    localparam logic [3:0] ST_PTD   = 4'd3;
    localparam logic [3:0] ST_PT    = 4'd4;
    localparam logic [3:0] ST_FRAC  = 4'd5;
    localparam logic [3:0] ST_EXP   = 4'd6;
    localparam logic [3:0] ST_ESIGN = 4'd7;
    localparam logic [3:0] ST_EDIG  = 4'd8;
    localparam logic [3:0] ST_TRAIL = 4'd9;
    localparam logic [3:0] ST_ERR   = 4'd10;

    logic [3:0] r_state, n_state;
    logic [3:0] step;
    logic       r_res_valid, n_res_valid;
    logic       r_is_valid, n_is_valid;
    logic       dig, spc, sgn, pnt, exm;
    logic       out_free, accepting;

    assign dig = (i_tok.cls == nlv_pkg::CLS_DIGIT);
    assign spc = (i_tok.cls == nlv_pkg::CLS_SPACE);
    assign sgn = (i_tok.cls == nlv_pkg::CLS_SIGN);
    assign pnt = (i_tok.cls == nlv_pkg::CLS_POINT);
    assign exm = (i_tok.cls == nlv_pkg::CLS_EXPO);

    always_comb begin
        step = ST_ERR;
        case (r_state)
            ST_START: begin
                if (spc)      step = ST_START;
                else if (sgn) step = ST_SIGN;
                else if (dig) step = ST_INT;
                else if (pnt) step = ST_PT;
            end
            ST_SIGN: begin
                if (dig)      step = ST_INT;
                else if (pnt) step = ST_PT;
            end
            ST_INT: begin
                if (dig)      step = ST_INT;
                else if (pnt) step = ST_PTD;
                else if (exm) step = ST_EXP;
                else if (spc) step = ST_TRAIL;
            end
            ST_PTD, ST_FRAC: begin
                if (dig)      step = ST_FRAC;
                else if (exm) step = ST_EXP;
                else if (spc) step = ST_TRAIL;
            end
            ST_PT: begin
                if (dig) step = ST_FRAC;
            end
            ST_EXP: begin
                if (sgn)      step = ST_ESIGN;
                else if (dig) step = ST_EDIG;
            end
            ST_ESIGN: begin
                if (dig) step = ST_EDIG;
            end
            ST_EDIG: begin
                if (dig)      step = ST_EDIG;
                else if (spc) step = ST_TRAIL;
            end
            ST_TRAIL: begin
                if (spc) step = ST_TRAIL;
            end
            default: step = ST_ERR;
        endcase
    end

    assign accepting = (step == ST_INT) || (step == ST_PTD) || (step == ST_FRAC) ||
                       (step == ST_EDIG) || (step == ST_TRAIL);

    // a last token waits only while the verdict register is still held
    assign out_free = !r_res_valid || i_res_ready;
    assign o_pop    = i_valid && (!i_tok.last || out_free);

    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid && !i_res_ready;
        n_is_valid  = r_is_valid;
        if (o_pop) begin
            if (i_tok.last) begin
                n_state     = ST_START;
                n_res_valid = 1'b1;
                n_is_valid  = accepting;
            end else begin
                n_state = step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_valid <= n_is_valid;
    end

    assign o_res_valid = r_res_valid;
    assign o_is_valid  = r_is_valid;

endmodule

[design/numeric_literal_validator.sv]
// ----------------------------------------------------------------------------
// numeric_literal_validator
// Checks strings, one character per request, for being a numeric literal.
//
//   channel  dir  payload           transfers
//   i_sym    in   symbol, is_last   one character per request
//   o_res    out  is_valid          one verdict per string, on its last char
//
// Up to one character per clock. A character is classified on acceptance,
// written into the queue, and stepped through the automaton when popped; a
// verdict is registered when its last character is popped from the queue.
// A held verdict stalls only the automaton; the two-entry queue keeps taking
// characters until it fills, then i_sym.ready drops.
// Synchronous active-low reset empties the queue and returns to the start state.
// ----------------------------------------------------------------------------
module numeric_literal_validator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nlv_sym_if.sink         i_sym,
    nlv_res_if.source       o_res
);

    logic          push, q_ready, q_valid, pop;
    nlv_pkg::t_tok push_tok, head_tok;

    nlv_front u_front (
        .i_valid   (i_sym.valid),
        .o_ready   (i_sym.ready),
        .i_symbol  (i_sym.symbol),
        .i_is_last (i_sym.is_last),
        .o_push    (push),
        .o_tok     (push_tok),
        .i_q_ready (q_ready)
    );

    nlv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_tok   (head_tok),
        .i_pop   (pop)
    );

    nlv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_tok       (head_tok),
        .o_pop       (pop),
        .o_res_valid (o_res.valid),
        .o_is_valid  (o_res.is_valid),
        .i_res_ready (o_res.ready)
    );

endmodule

[design/nlv_checker.sv]
// ----------------------------------------------------------------------------
// nlv_checker
// Port-level checks on the literal validator, bound to its top level.
// ----------------------------------------------------------------------------
`include "numeric_literal_validator_defines.svh"

module nlv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_is_valid
);

    `NLV_ASSERT_RST(a_rst_clears_out, !i_rst_n, !i_out_valid, "verdict pending after reset")
    `NLV_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_is_valid), "stalled verdict changed")
    `NLV_ASSERT_NOW(a_backpressure_cause, !i_in_ready, i_out_valid, "input stalled without a held verdict")
    `NLV_ASSERT_NEXT(a_stall_persists, !i_in_ready && !i_out_ready, !i_in_ready, "input ready rose while output stalled")

endmodule

bind numeric_literal_validator nlv_checker u_nlv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_sym.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_is_valid (o_res.is_valid)
);
